// ----- hdl/pidc_pkg.sv -----
package pidc_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETPOINT   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_LOW  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_HIGH = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D     = 3'd5;

   // proportional gain after reset: 1.0 in Q8.8
   localparam int GAIN_P_RESET = 256;

   // product terms saturate at +/- 2^61 before summing
   localparam int TERM_SAT_BITS = 61;

endpackage

// ----- hdl/pidc_req_if.sv -----
interface pidc_req_if #(
   parameter int DATA_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- hdl/pidc_rsp_if.sv -----
interface pidc_rsp_if #(
   parameter int DATA_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

// ----- hdl/pid_controller_step_top.sv -----
// PID controller step: each sample item on req yields one drive item on rsp.
// error = setpoint - sample; the integral adds (gain_i*error)>>>F and is clamped to
// [limit_low, limit_high]; drive = clamp((gain_p*error)>>>F + integral
// - (gain_d*(sample - previous sample))>>>F), gains signed Q.F with F = GAIN_FRAC_BITS.
// Throughput is one item per clock unless rsp stalls; an item waits in sample_ff
// and enters the rsp register when it fires. The rate is set by the combinational
// loop through the three multipliers, the integral add and clamp, and the output
// add and clamp, which updates the integral and previous sample before the next
// item is evaluated. Registers are written through csr_* and should only change
// while no item is in flight.
module pid_controller_step_top #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pidc_req_if.sink                              req,
   pidc_rsp_if.source                            rsp,
   input  logic                                  csr_write_enable,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [DATA_WIDTH-1:0]                 csr_write_data
);

   localparam int DW = DATA_WIDTH;
   localparam int F  = GAIN_FRAC_BITS;
   // exact product of a DW-bit gain and a (DW+1)-bit difference
   localparam int PW = 2 * DW + 1;
   // width of a shifted product term before saturation, at least the sign bit
   localparam int TW = (2 * DW - F > 1) ? 2 * DW - F : 1;
   // width after saturation at +/- 2^61
   localparam int CW = (TW > pidc_pkg::TERM_SAT_BITS + 1) ? pidc_pkg::TERM_SAT_BITS + 2 : TW;
   localparam int MW = (CW > DW) ? CW : DW;
   localparam int SW = MW + 2;

   localparam int LANES  = 3;
   localparam int LANE_I = 0;
   localparam int LANE_P = 1;
   localparam int LANE_D = 2;

   // configuration registers
   logic signed [DW-1:0] setpoint_ff;
   logic signed [DW-1:0] limit_low_ff;
   logic signed [DW-1:0] limit_high_ff;
   logic signed [DW-1:0] gain_p_ff;
   logic signed [DW-1:0] gain_i_ff;
   logic signed [DW-1:0] gain_d_ff;

   // controller state
   logic signed [DW-1:0] integral_ff, integral_in;
   logic signed [DW-1:0] prev_sample_ff;

   // input stage and result stage
   logic                 in_valid_ff, in_valid_in;
   logic signed [DW-1:0] sample_ff;
   logic                 out_valid_ff, out_valid_in;
   logic signed [DW-1:0] drive_ff, drive_in;

   logic                 req_take;
   logic                 advance;
   logic                 fire;

   logic signed [DW:0]   error_val;
   logic signed [DW:0]   delta_val;
   logic signed [DW-1:0] lane_gain [LANES];
   logic signed [DW:0]   lane_arg  [LANES];
   logic signed [CW-1:0] lane_term [LANES];

   logic signed [SW-1:0] integ_sum;
   logic signed [SW-1:0] total_sum;
   logic signed [SW-1:0] lo_ext;
   logic signed [SW-1:0] hi_ext;
   logic signed [DW-1:0] drive_val;

   // handshake
   assign advance   = !out_valid_ff || rsp.ready;
   assign fire      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign rsp.valid = out_valid_ff;
   assign rsp.drive = drive_ff;

   // configuration writes, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= '0;
         limit_low_ff  <= {1'b1, {(DW-1){1'b0}}};
         limit_high_ff <= {1'b0, {(DW-1){1'b1}}};
         gain_p_ff     <= DW'(pidc_pkg::GAIN_P_RESET);
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pidc_pkg::CSR_SETPOINT:   setpoint_ff   <= csr_write_data;
            pidc_pkg::CSR_LIMIT_LOW:  limit_low_ff  <= csr_write_data;
            pidc_pkg::CSR_LIMIT_HIGH: limit_high_ff <= csr_write_data;
            pidc_pkg::CSR_GAIN_P:     gain_p_ff     <= csr_write_data;
            pidc_pkg::CSR_GAIN_I:     gain_i_ff     <= csr_write_data;
            pidc_pkg::CSR_GAIN_D:     gain_d_ff     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // error against setpoint, derivative on the measurement
   assign error_val = (DW+1)'(setpoint_ff) - (DW+1)'(sample_ff);
   assign delta_val = (DW+1)'(sample_ff) - (DW+1)'(prev_sample_ff);

   assign lane_gain[LANE_I] = gain_i_ff;
   assign lane_gain[LANE_P] = gain_p_ff;
   assign lane_gain[LANE_D] = gain_d_ff;
   assign lane_arg[LANE_I]  = error_val;
   assign lane_arg[LANE_P]  = error_val;
   assign lane_arg[LANE_D]  = delta_val;

   // one multiplier per term, floor shift, saturation for very wide terms
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] shifted;
      logic signed [TW-1:0] term;

      assign prod    = lane_gain[g] * lane_arg[g];
      assign shifted = prod >>> F;
      assign term    = shifted[TW-1:0];

      if (TW > pidc_pkg::TERM_SAT_BITS + 1) begin : g_sat
         localparam logic signed [TW-1:0] TERM_HI =
            TW'(64'sd1 <<< pidc_pkg::TERM_SAT_BITS);
         localparam logic signed [TW-1:0] TERM_LO = -TERM_HI;
         logic signed [TW-1:0] sat;
         always_comb begin
            if (term > TERM_HI) begin
               sat = TERM_HI;
            end else if (term < TERM_LO) begin
               sat = TERM_LO;
            end else begin
               sat = term;
            end
         end
         assign lane_term[g] = sat[CW-1:0];
      end else begin : g_nosat
         assign lane_term[g] = term;
      end
   end

   assign lo_ext = SW'(limit_low_ff);
   assign hi_ext = SW'(limit_high_ff);

   // integral update with anti-windup clamp, then output sum and clamp
   always_comb begin
      integ_sum = SW'(integral_ff) + SW'(lane_term[LANE_I]);
      if (integ_sum > hi_ext) begin
         integral_in = limit_high_ff;
      end else if (integ_sum < lo_ext) begin
         integral_in = limit_low_ff;
      end else begin
         integral_in = integ_sum[DW-1:0];
      end

      total_sum = SW'(lane_term[LANE_P]) + SW'(integral_in) - SW'(lane_term[LANE_D]);
      if (total_sum > hi_ext) begin
         drive_val = limit_high_ff;
      end else if (total_sum < lo_ext) begin
         drive_val = limit_low_ff;
      end else begin
         drive_val = total_sum[DW-1:0];
      end
   end

   // next values of the stage valids and the result
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      drive_in = fire ? drive_val : drive_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         integral_ff    <= '0;
         prev_sample_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            integral_ff    <= integral_in;
            prev_sample_ff <= sample_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req.sample;
      end
      drive_ff <= drive_in;
   end

endmodule
